// File: hdl/acmv_pkg.sv
// acmv_pkg: shared types, constants and AES helper functions for the CBC-MAC checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package acmv_pkg;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_SIG_HIGH = 2'd2;
  localparam logic [1:0] REG_SIG_LOW  = 2'd3;

  localparam int QueueDepth = 4;
  localparam int QueueAw    = 2;

  // Job from the front to the back: a block to absorb, a check, or both.
  typedef struct packed {
    logic         restart;  // begin from a zero chain value
    logic         absorb;   // encrypt block xor chain
    logic         check;    // compare and report afterwards
    logic [127:0] block;
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] s [256];
    s = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return s[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit word; byte 0 is the most significant.
  function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
    return w[127-8*i -: 8];
  endfunction

  // Next round key from the current one and its round constant.
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // One round without the key add: SubBytes, ShiftRows, MixColumns unless last.
  function automatic logic [127:0] round_fn(input logic [127:0] st, input logic last);
    logic [7:0] tmp [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        tmp[4*c+r] = sbox(get_byte(st, 4*((c+r)%4)+r));
    for (int c = 0; c < 4; c++) begin
      a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        o[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        o[127-32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                             a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// File: hdl/acmv_stream_if.sv
// acmv_stream_if: valid/ready channel carrying a generic payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface acmv_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/acmv_front.sv
// acmv_front: takes command words, assembles 16-byte blocks, emits jobs.
// Depends on acmv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module acmv_front import acmv_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_data_byte,
  output logic            job_valid,
  input  wire logic       job_ready,
  output job_t            job
);
  logic [127:0] buf_r, buf_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic         pend_r, pend_nxt;   // a start not yet passed to the back
  logic         acc;
  cmd_t         cmd;
  logic [127:0] filled;

  assign cmd      = cmd_t'(in_command);
  assign acc      = in_valid && in_ready;
  assign filled   = buf_r | ({120'd0, in_data_byte} << (8 * (4'd15 - cnt_r)));

  // Only adds that close a block and finishes need a queue slot.
  always_comb begin
    in_ready  = 1'b1;
    job_valid = 1'b0;
    job       = '{restart: pend_r, absorb: 1'b0, check: 1'b0, block: filled};
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    case (cmd)
      CMD_START: begin
        if (in_valid) begin
          buf_nxt = '0; cnt_nxt = '0; pend_nxt = 1'b1;
        end
      end
      CMD_ADD: begin
        if (cnt_r == 4'd15) begin
          in_ready  = job_ready;
          job_valid = in_valid;
          job.absorb = 1'b1;
          if (acc) begin
            buf_nxt = '0; cnt_nxt = '0; pend_nxt = 1'b0;
          end
        end else if (in_valid) begin
          buf_nxt = filled; cnt_nxt = cnt_r + 4'd1;
        end
      end
      CMD_FINISH: begin
        in_ready   = job_ready;
        job_valid  = in_valid;
        job.absorb = (cnt_r != 4'd0);
        job.check  = 1'b1;
        job.block  = buf_r;
        if (acc) begin
          buf_nxt = '0; cnt_nxt = '0; pend_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; pend_r <= 1'b0; buf_r <= '0;
    end else begin
      cnt_r <= cnt_nxt; pend_r <= pend_nxt; buf_r <= buf_nxt;
    end
  end
endmodule
`default_nettype wire

// File: hdl/acmv_queue.sv
// acmv_queue: small FIFO of jobs between front and back.
// Depends on acmv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module acmv_queue import acmv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  job_t      wr_job,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output job_t      rd_job
);
  job_t             mem [QueueDepth];
  logic [QueueAw-1:0] wp_r, rp_r;
  logic [QueueAw:0]   cnt_r;
  logic wr, rd;

  assign wr_ready = (cnt_r != QueueAw'(0) + (QueueAw+1)'(QueueDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wr_job;
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QueueAw+1)'(wr) - (QueueAw+1)'(rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QueueAw+1)'(QueueDepth)) else $error("queue overflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    wr && !rd |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count");
  a_empty_no_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> !rd) else $error("read of empty queue");
endmodule
`default_nettype wire

// File: hdl/acmv_back.sv
// acmv_back: iterative AES-128 round unit, chain value and MAC compare.
// Depends on acmv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module acmv_back import acmv_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         job_valid,
  output logic              job_ready,
  input  job_t              job,
  input  wire logic [127:0] key,
  input  wire logic [127:0] sig,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_match
);
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_SEND} state_t;
  state_t       state_r;
  logic [127:0] chain_r, st_r, rk_r;
  logic [3:0]   rnd_r;
  logic [7:0]   rc_r;
  logic         chk_r, out_valid_r, out_match_r;
  logic [127:0] nk, ns, base;

  assign out_valid = out_valid_r;
  assign out_match = out_match_r;
  assign nk = key_step(rk_r, rc_r);
  assign ns = round_fn(st_r, rnd_r == 4'd10) ^ nk;
  assign base = job.restart ? '0 : chain_r;
  assign job_ready = (state_r == S_IDLE) && !(out_valid_r && !out_ready);

  // One AES round per cycle; round key expanded alongside.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; chain_r <= '0; out_valid_r <= 1'b0;
      st_r <= '0; rk_r <= '0; rnd_r <= '0; rc_r <= '0; chk_r <= 1'b0; out_match_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            if (job.absorb) begin
              st_r <= base ^ job.block ^ key;
              rk_r <= key; rnd_r <= 4'd1; rc_r <= 8'h01;
              chk_r <= job.check; state_r <= S_RUN;
              if (job.restart) chain_r <= '0;
            end else begin
              chain_r <= base;
              out_valid_r <= 1'b1; out_match_r <= (base == sig);
            end
          end
        end
        S_RUN: begin
          st_r <= ns; rk_r <= nk; rnd_r <= rnd_r + 4'd1;
          rc_r <= xtime(rc_r);
          if (rnd_r == 4'd10) begin
            chain_r <= ns;
            if (chk_r) begin
              out_valid_r <= 1'b1; out_match_r <= (ns == sig);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> rnd_r >= 4'd1 && rnd_r <= 4'd10) else $error("round count");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> !job_ready) else $error("job taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_match_r)) else $error("result lost");
endmodule
`default_nettype wire

// File: hdl/aes_cbc_mac_verify.sv
// aes_cbc_mac_verify: top level of the AES-128 CBC-MAC checker.
// Depends on acmv_pkg, acmv_stream_if, acmv_front, acmv_queue, acmv_back.
//
//   channel  dir  payload                     handshake
//   in       in   command[1:0], data_byte[7:0] valid/ready
//   out      out  match                       valid/ready
//   cfg      in   index[1:0], data[63:0]      write enable
//
// Start and non-closing add words are accepted one per cycle.
// A block runs through the iterative round unit one AES round a cycle,
// so byte streams at one word per cycle are sustained while results are taken; a 4-entry
// job queue absorbs the finish. A pending result holds in the output register until taken.
// Reset (rst_n low, synchronous) clears chain, buffer, count and registers.
`timescale 1ns / 1ps
`default_nettype none
module aes_cbc_mac_verify import acmv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  acmv_stream_if.sink      in_ch,
  acmv_stream_if.source    out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  logic [63:0] key_high_r, key_low_r, sig_high_r, sig_low_r;
  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0; key_low_r <= '0; sig_high_r <= '0; sig_low_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_HIGH: key_high_r <= cfg_data;
        REG_KEY_LOW:  key_low_r  <= cfg_data;
        REG_SIG_HIGH: sig_high_r <= cfg_data;
        REG_SIG_LOW:  sig_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  acmv_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_command(in_ch.payload[9:8]), .in_data_byte(in_ch.payload[7:0]),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  acmv_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
  );

  acmv_back u_back (
    .clk, .rst_n,
    .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .key({key_high_r, key_low_r}), .sig({sig_high_r, sig_low_r}),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_match(out_ch.payload[0])
  );
endmodule
`default_nettype wire

// File: tb/sv/tb_aes_cbc_mac_verify.sv
// tb_aes_cbc_mac_verify: self-checking bench for the AES-128 CBC-MAC checker.
// Depends on acmv_pkg, acmv_stream_if and aes_cbc_mac_verify; predicts each match bit
// with its own AES-128 model and checks it against the result channel.
`timescale 1ns / 1ps
module tb_aes_cbc_mac_verify;
  import acmv_pkg::*;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] data;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;

  acmv_stream_if #(.W(10)) in_if ();
  acmv_stream_if #(.W(1))  out_if ();

  aes_cbc_mac_verify dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  word_t      word_queue[$];
  logic       match_expected[$];
  int         errors = 0;
  int         cycles = 0;
  logic       fired = 1'b0;
  logic       no_idle = 1'b0;
  logic       hold_req = 1'b0;
  int         hold_left = 0;

  // predictor state
  logic [7:0]   sb [256];
  logic [127:0] key_q = '0, sig_q = '0, chain_q = '0, buf_q = '0;
  int           fill_q = 0;

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // Build the S-box from the field inverse and the affine map.
  function automatic void build_sbox();
    logic [7:0] inv, x;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gmul(inv, a[7:0]);
      if (a == 0) inv = 8'h00;
      x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sb[a] = x;
    end
  endfunction

  // AES-128 encryption; byte 0 is bits 127..120, state byte 4*col+row.
  function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                              input logic [127:0] blk);
    logic [7:0]  st [16], tmp [16], rk [16], t [4];
    logic [7:0]  rc, a0, a1, a2, a3, all;
    logic [127:0] o;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      st[i] = blk[127-8*i -: 8] ^ rk[i];
    end
    for (int r = 1; r <= 10; r++) begin
      // advance the round key
      t[0] = sb[rk[13]] ^ rc; t[1] = sb[rk[14]]; t[2] = sb[rk[15]]; t[3] = sb[rk[12]];
      for (int w = 0; w < 4; w++)
        for (int c = 0; c < 4; c++) begin
          rk[4*w+c] ^= t[c];
          t[c] = rk[4*w+c];
        end
      rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) tmp[4*c+i] = sb[st[4*((c+i)%4)+i]];
      for (int c = 0; c < 4; c++) begin
        a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        if (r != 10) begin
          a0 = tmp[4*c] ^ all ^ gmul(tmp[4*c] ^ tmp[4*c+1], 8'h02);
          a1 = tmp[4*c+1] ^ all ^ gmul(tmp[4*c+1] ^ tmp[4*c+2], 8'h02);
          a2 = tmp[4*c+2] ^ all ^ gmul(tmp[4*c+2] ^ tmp[4*c+3], 8'h02);
          a3 = tmp[4*c+3] ^ all ^ gmul(tmp[4*c+3] ^ tmp[4*c], 8'h02);
        end
        st[4*c] = a0 ^ rk[4*c]; st[4*c+1] = a1 ^ rk[4*c+1];
        st[4*c+2] = a2 ^ rk[4*c+2]; st[4*c+3] = a3 ^ rk[4*c+3];
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = st[i];
    return o;
  endfunction

  // Append one byte to the chain; absorb on a full block.
  function automatic void chain_byte(input logic [7:0] b);
    buf_q[127-8*fill_q -: 8] = b;
    fill_q = (fill_q + 1) % 16;
    if (fill_q == 0) begin
      chain_q = aes_encrypt(key_q, chain_q ^ buf_q);
      buf_q = '0;
    end
  endfunction

  function automatic void predict_word(input cmd_t cmd, input logic [7:0] b);
    case (cmd)
      CMD_START: begin
        chain_q = '0; buf_q = '0; fill_q = 0;
      end
      CMD_ADD: chain_byte(b);
      CMD_FINISH: begin
        while (fill_q != 0) chain_byte(8'h00);
        match_expected.push_back(chain_q == sig_q);
      end
      default: ;
    endcase
  endfunction

  task automatic report(input string what, input logic got, input logic want);
    $display("error: %s got %0b expected %0b at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Track accepted input words and check results.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    fired <= in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready)
      predict_word(cmd_t'(in_if.payload[9:8]), in_if.payload[7:0]);
    if (rst_n && out_if.valid && out_if.ready) begin
      if (match_expected.size() == 0) report("unexpected match word", out_if.payload[0], 1'b0);
      else begin
        if (out_if.payload[0] !== match_expected[0])
          report("match", out_if.payload[0], match_expected[0]);
        void'(match_expected.pop_front());
      end
    end
    if (cycles > 400000) begin
      $display("timeout with %0d words pending", word_queue.size());
      $display("aes_cbc_mac_verify: mismatch");
      $finish;
    end
  end

  // Drive input words from the queue with random gaps.
  always @(negedge clk) begin
    if (!in_if.valid || fired) begin
      if (rst_n && word_queue.size() > 0 && (no_idle || $urandom_range(99) >= 17)) begin
        in_if.payload <= {word_queue[0].cmd, word_queue[0].data};
        in_if.valid <= 1'b1;
        void'(word_queue.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= no_idle || $urandom_range(99) >= 17;
    end
  end

  task automatic push_word(input cmd_t cmd, input logic [7:0] b);
    word_t w;
    w.cmd = cmd;
    w.data = b;
    word_queue.push_back(w);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY_HIGH: key_q[127:64] = val;
      REG_KEY_LOW:  key_q[63:0] = val;
      REG_SIG_HIGH: sig_q[127:64] = val;
      default:      sig_q[63:0] = val;
    endcase
  endtask

  // Hold until every word is taken and every result is in, then let blocks drain.
  task automatic drain();
    while (word_queue.size() > 0 || in_if.valid || match_expected.size() > 0)
      @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Queue a random message; optionally set the signature to its MAC first.
  task automatic queue_message(input logic make_match);
    logic [7:0]   msg[$];
    logic [127:0] mac, blk;
    int           len, n;
    len = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(20);
    for (int i = 0; i < len; i++) msg.push_back(8'($urandom_range(255)));
    if (make_match) begin
      mac = '0;
      n = 0;
      blk = '0;
      for (int i = 0; i < (len + 15) / 16 * 16; i++) begin
        blk[127-8*n -: 8] = (i < len) ? msg[i] : 8'h00;
        n++;
        if (n == 16) begin
          mac = aes_encrypt(key_q, mac ^ blk);
          blk = '0; n = 0;
        end
      end
      write_reg(REG_SIG_HIGH, mac[127:64]);
      write_reg(REG_SIG_LOW, mac[63:0]);
      push_word(CMD_START, 8'($urandom_range(255)));
    end else if ($urandom_range(9) != 0) begin
      push_word(CMD_START, 8'($urandom_range(255)));
    end
    foreach (msg[i]) begin
      push_word(CMD_ADD, msg[i]);
      if (!make_match && $urandom_range(19) == 0)
        push_word(CMD_NONE, 8'($urandom_range(255)));
    end
    if (!make_match && $urandom_range(14) == 0) return;
    push_word(CMD_FINISH, 8'($urandom_range(255)));
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    build_sbox();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty message with zero registers, repeated finish, unused command, full and partial blocks
    push_word(CMD_FINISH, 8'h00);
    push_word(CMD_FINISH, 8'hff);
    push_word(CMD_NONE, 8'hff);
    push_word(CMD_START, 8'h00);
    for (int i = 0; i < 16; i++) push_word(CMD_ADD, i[0] ? 8'hff : 8'h00);
    push_word(CMD_FINISH, 8'h00);
    push_word(CMD_ADD, 8'hff);
    push_word(CMD_FINISH, 8'h00);
    drain();

    // phases under several key settings, extremes first
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_KEY_HIGH, '1); write_reg(REG_KEY_LOW, '1); end
        1: begin write_reg(REG_KEY_HIGH, '0); write_reg(REG_KEY_LOW, '0); end
        default: begin
          write_reg(REG_KEY_HIGH, {$urandom, $urandom});
          write_reg(REG_KEY_LOW, {$urandom, $urandom});
        end
      endcase
      queue_message(1'b1);
      drain();
      write_reg(REG_SIG_HIGH, (ph == 1) ? 64'h0 : {$urandom, $urandom});
      write_reg(REG_SIG_LOW, (ph == 0) ? '1 : {$urandom, $urandom});
      no_idle = (ph == 3);
      if (ph == 2) begin
        // long receiver hold-off while finishes pile up
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++) push_word(CMD_FINISH, 8'h00);
      end
      while (word_queue.size() < 90) queue_message(1'b0);
      drain();
      no_idle = 1'b0;
    end

    if (errors == 0) begin
      $display("aes_cbc_mac_verify: match");
    end else begin
      $display("aes_cbc_mac_verify: mismatch");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/acmv_pkg.sv
hdl/acmv_stream_if.sv
hdl/acmv_front.sv
hdl/acmv_queue.sv
hdl/acmv_back.sv
hdl/aes_cbc_mac_verify.sv
tb/sv/tb_aes_cbc_mac_verify.sv
